FILE: rtl/core/svm_pkg.sv
// ============================================================================
// svm_pkg
// Shared types and constants for the eight-voice sample playback mixer.
// ============================================================================
`default_nettype none

package svm_pkg;

    // Sizing of the mixer.
    localparam int VOICE_COUNT  = 8;
    localparam int EFFECT_COUNT = 10;
    localparam int SLOT_DEPTH   = 65536;
    localparam int SAMPLE_BITS  = 16;
    localparam int MASK_BITS    = 11;
    localparam int QUEUE_DEPTH  = 4;

    // Derived widths.
    localparam int KIND_W      = 2;
    localparam int EFF_W       = 4;
    localparam int POS_W       = $clog2(SLOT_DEPTH);
    localparam int LEN_W       = POS_W + 1;
    localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int EIDX_W      = (EFFECT_COUNT > 1) ? $clog2(EFFECT_COUNT) : 1;
    localparam int STORE_DEPTH = EFFECT_COUNT * SLOT_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SUM_W       = SAMPLE_BITS + VOICE_W + 1;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Output clamp at 0.85 of full scale, rounded to nearest.
    localparam int CLAMP_LIMIT = (85 * (1 << (SAMPLE_BITS - 1)) + 50) / 100;

    // Highest effect a trigger mask can start.
    localparam int TRIG_LAST = (EFFECT_COUNT < MASK_BITS - 1) ? EFFECT_COUNT : MASK_BITS - 1;

    // Input kind codes.
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd2;

    // Input word.
    typedef struct packed {
        logic [KIND_W-1:0]             kind;
        logic [EFF_W-1:0]              effect_id;
        logic [15:0]                   sample_index;
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          last_word;
        logic [MASK_BITS-1:0]          trigger_mask;
        logic                          reset_voices;
    } cmd_word_t;

    // Result word.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mixed_sample;
        logic                          audible;
    } mix_word_t;

    // Operations handed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRIG,
        OP_FRAME
    } op_kind_t;

    typedef struct packed {
        op_kind_t                      kind;
        logic [EIDX_W-1:0]             eff_idx;
        logic [POS_W-1:0]              pos;
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last_word;
        logic [MASK_BITS-1:0]          mask;
        logic                          reset_voices;
    } op_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sample_voice_mixer_top.sv
// Path: a frame word passes the front stage and the queue, then the engine,
// which visits one voice per cycle, drains the last read and emits the mix.
// The engine finishes each operation before it takes the next from the queue;
// a trigger steps through its effects in ascending order, a load is a single write.
// Reset clears voices, lengths, pointers and handshakes at once; the sample
// store has no reset and no clearing pass, so words are accepted right away.
// ============================================================================
// sample_voice_mixer_top
// Eight-voice sample playback mixer with a decoding front end, an operation
// queue and a voice engine that owns the sample store.
// ============================================================================
`default_nettype none

module sample_voice_mixer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire svm_pkg::cmd_word_t cmd,
    output logic                    mix_valid,
    input  wire logic               mix_stall,
    output svm_pkg::mix_word_t      mix
);
    import svm_pkg::*;

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    op_t       push_op;
    op_t       head_op;

    // Decoding front end.
    svm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    // Operation queue.
    svm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .status  (q_status)
    );

    // Voice engine.
    svm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .mix_valid (mix_valid),
        .mix_stall (mix_stall),
        .mix       (mix)
    );

endmodule

`default_nettype wire

FILE: rtl/core/svm_front.sv
// ============================================================================
// svm_front
// Accepts input words, decodes them into engine operations and drops
// words that have no effect, then hands operations to the queue.
// ============================================================================
`default_nettype none

module svm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire svm_pkg::cmd_word_t cmd,
    input  wire svm_pkg::q_status_t q_status,
    output logic                   q_push,
    output svm_pkg::op_t           q_op
);
    import svm_pkg::*;

    logic op_valid_reg, op_valid_next;
    op_t  op_reg, op_next;
    logic accept;
    logic keep;
    op_t  decoded;

    // The holding stage blocks new words only while the queue is full.
    assign cmd_stall = op_valid_reg && q_status.full;
    assign accept    = cmd_valid && !cmd_stall;
    assign q_push    = op_valid_reg && !q_status.full;
    assign q_op      = op_reg;

    // Decode one input word. Loads to a missing effect and the unused kind
    // are dropped here. A 16-bit index always falls inside a slot.
    always_comb
    begin
        decoded.kind         = OP_LOAD;
        decoded.eff_idx      = EIDX_W'(cmd.effect_id - EFF_W'(1));
        decoded.pos          = cmd.sample_index;
        decoded.value        = cmd.sample_value;
        decoded.last_word    = cmd.last_word;
        decoded.mask         = cmd.trigger_mask;
        decoded.reset_voices = cmd.reset_voices;
        keep                 = 1'b0;
        case (cmd.kind)
            KIND_LOAD:
            begin
                decoded.kind = OP_LOAD;
                keep = (cmd.effect_id != '0) &&
                       ({1'b0, cmd.effect_id} <= (EFF_W + 1)'(EFFECT_COUNT));
            end
            KIND_TRIGGER:
            begin
                decoded.kind = OP_TRIG;
                keep = 1'b1;
            end
            KIND_FRAME:
            begin
                decoded.kind = OP_FRAME;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Next value of the holding stage.
    always_comb
    begin
        op_valid_next = op_valid_reg;
        op_next       = op_reg;
        if (q_push)
        begin
            op_valid_next = 1'b0;
        end
        if (accept)
        begin
            op_valid_next = keep;
            op_next       = decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/svm_queue.sv
// ============================================================================
// svm_queue
// Short first-in first-out queue of decoded operations between the front
// end and the engine.
// ============================================================================
`default_nettype none

module svm_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire svm_pkg::op_t push_op,
    input  wire logic         pop,
    output svm_pkg::op_t      head_op,
    output svm_pkg::q_status_t status
);
    import svm_pkg::*;

    op_t               entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_op      = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/svm_engine.sv
// ============================================================================
// svm_engine
// Carries out operations: writes the sample store, starts voices by round
// robin, and mixes one frame by visiting one voice per cycle.
// ============================================================================
`default_nettype none

module svm_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire svm_pkg::q_status_t q_status,
    input  wire svm_pkg::op_t       q_op,
    output logic                    q_pop,
    output logic                    mix_valid,
    input  wire logic               mix_stall,
    output svm_pkg::mix_word_t      mix
);
    import svm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic signed [SUM_W-1:0] LIMIT_POS = SUM_W'(CLAMP_LIMIT);
    localparam logic signed [SUM_W-1:0] LIMIT_NEG = -SUM_W'(CLAMP_LIMIT);

    // Sample store, one slot per effect, no reset.
    logic signed [SAMPLE_BITS-1:0] store_mem [0:STORE_DEPTH-1];
    logic                          wr_en;
    logic [STORE_AW-1:0]           wr_addr;
    logic                          rd_en;
    logic [STORE_AW-1:0]           rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg, rd_valid_next;

    // Control and voice state.
    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg [0:EFFECT_COUNT-1];
    logic [LEN_W-1:0]          len_next [0:EFFECT_COUNT-1];
    logic [EFF_W-1:0]          veff_reg [0:VOICE_COUNT-1];
    logic [EFF_W-1:0]          veff_next [0:VOICE_COUNT-1];
    logic [POS_W-1:0]          vpos_reg [0:VOICE_COUNT-1];
    logic [POS_W-1:0]          vpos_next [0:VOICE_COUNT-1];
    logic [VOICE_W-1:0]        next_voice_reg, next_voice_next;
    logic [VOICE_W-1:0]        voice_reg, voice_next;
    logic [EFF_W-1:0]          trig_eff_reg, trig_eff_next;
    logic [MASK_BITS-1:0]      mask_reg, mask_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [63:0]               frames_reg, frames_next;
    logic                      out_valid_reg, out_valid_next;
    mix_word_t                 out_word_reg, out_word_next;

    // Scan helpers for the current voice.
    logic [EFF_W-1:0]          cur_eff;
    logic [EIDX_W-1:0]         cur_idx;
    logic [LEN_W-1:0]          cur_len;
    logic [LEN_W-1:0]          cur_pos;
    logic [LEN_W-1:0]          cur_pos_inc;
    logic signed [SUM_W-1:0]   clamped;
    logic                      out_free;

    assign mix_valid = out_valid_reg;
    assign mix       = out_word_reg;
    assign out_free  = !out_valid_reg || !mix_stall;

    assign cur_eff     = veff_reg[voice_reg];
    assign cur_idx     = EIDX_W'(cur_eff - EFF_W'(1));
    assign cur_len     = len_reg[cur_idx];
    assign cur_pos     = {1'b0, vpos_reg[voice_reg]};
    assign cur_pos_inc = cur_pos + LEN_W'(1);

    // Clamp the frame sum to the symmetric limit.
    always_comb
    begin
        if (sum_reg > LIMIT_POS)
        begin
            clamped = LIMIT_POS;
        end
        else if (sum_reg < LIMIT_NEG)
        begin
            clamped = LIMIT_NEG;
        end
        else
        begin
            clamped = sum_reg;
        end
    end

    // Next-state logic for the engine.
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        veff_next       = veff_reg;
        vpos_next       = vpos_reg;
        next_voice_next = next_voice_reg;
        voice_next      = voice_reg;
        trig_eff_next   = trig_eff_reg;
        mask_next       = mask_reg;
        sum_next        = sum_reg;
        frames_next     = frames_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = {q_op.eff_idx, q_op.pos};
        rd_en           = 1'b0;
        rd_addr         = {cur_idx, vpos_reg[voice_reg]};

        // Store data read in the previous cycle joins the sum.
        if (rd_valid_reg)
        begin
            sum_next = sum_reg + SUM_W'(rd_data_reg);
        end

        // The output register empties when its word is taken.
        if (out_valid_reg && !mix_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        OP_LOAD:
                        begin
                            wr_en = 1'b1;
                            if (q_op.last_word)
                            begin
                                len_next[q_op.eff_idx] = {1'b0, q_op.pos} + LEN_W'(1);
                            end
                        end
                        OP_TRIG:
                        begin
                            if (q_op.reset_voices)
                            begin
                                for (int v = 0; v < VOICE_COUNT; v++)
                                begin
                                    veff_next[v] = '0;
                                    vpos_next[v] = '0;
                                end
                                next_voice_next = '0;
                            end
                            mask_next     = q_op.mask;
                            trig_eff_next = EFF_W'(1);
                            state_next    = ST_TRIG;
                        end
                        OP_FRAME:
                        begin
                            voice_next = '0;
                            sum_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // One effect per cycle, in ascending order.
            ST_TRIG:
            begin
                if (mask_reg[trig_eff_reg])
                begin
                    veff_next[next_voice_reg] = trig_eff_reg;
                    vpos_next[next_voice_reg] = '0;
                    if (next_voice_reg == VOICE_W'(VOICE_COUNT - 1))
                    begin
                        next_voice_next = '0;
                    end
                    else
                    begin
                        next_voice_next = next_voice_reg + VOICE_W'(1);
                    end
                end
                if (trig_eff_reg == EFF_W'(TRIG_LAST))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    trig_eff_next = trig_eff_reg + EFF_W'(1);
                end
            end

            // One voice per cycle: fetch its word and advance or free it.
            ST_SCAN:
            begin
                if (cur_eff != '0)
                begin
                    if (cur_pos < cur_len)
                    begin
                        rd_en = 1'b1;
                    end
                    if (cur_pos_inc >= cur_len)
                    begin
                        veff_next[voice_reg] = '0;
                        vpos_next[voice_reg] = '0;
                    end
                    else
                    begin
                        vpos_next[voice_reg] = cur_pos_inc[POS_W-1:0];
                    end
                end
                if (voice_reg == VOICE_W'(VOICE_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    voice_next = voice_reg + VOICE_W'(1);
                end
            end

            // The last fetched word is added during this cycle.
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.mixed_sample = clamped[SAMPLE_BITS-1:0];
                    out_word_next.audible      = (clamped != '0);
                    frames_next                = frames_reg + 64'd1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_valid_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int e = 0; e < EFFECT_COUNT; e++)
            begin
                len_reg[e] <= '0;
            end
            for (int v = 0; v < VOICE_COUNT; v++)
            begin
                veff_reg[v] <= '0;
                vpos_reg[v] <= '0;
            end
            next_voice_reg <= '0;
            voice_reg      <= '0;
            trig_eff_reg   <= '0;
            mask_reg       <= '0;
            sum_reg        <= '0;
            frames_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_word_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            veff_reg       <= veff_next;
            vpos_reg       <= vpos_next;
            next_voice_reg <= next_voice_next;
            voice_reg      <= voice_next;
            trig_eff_reg   <= trig_eff_next;
            mask_reg       <= mask_next;
            sum_reg        <= sum_next;
            frames_reg     <= frames_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            out_word_reg   <= out_word_next;
        end
    end

    // Sample store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= q_op.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/svm_checker.sv
// ============================================================================
// svm_checker
// Port-level checks for the mixer, bound to the top level.
// ============================================================================
`default_nettype none

module svm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_stall,
    input wire svm_pkg::cmd_word_t cmd,
    input wire logic               mix_valid,
    input wire logic               mix_stall,
    input wire svm_pkg::mix_word_t mix
);
    import svm_pkg::*;

    // A stalled command word stays offered and unchanged.
    a_hold_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command word changed while stalled");

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix_stall |=> mix_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && mix_stall |=> $stable(mix))
        else $error("result changed while stalled");

    // The audible flag tracks a nonzero mix.
    a_audible: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> (mix.audible == (mix.mixed_sample != '0)))
        else $error("audible flag disagrees with the mix");

    // The mix never leaves the clamp range.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> ((mix.mixed_sample <= SAMPLE_BITS'(CLAMP_LIMIT)) &&
                       (mix.mixed_sample >= -SAMPLE_BITS'(CLAMP_LIMIT))))
        else $error("mix outside the clamp range");

endmodule

bind sample_voice_mixer_top svm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .mix_valid (mix_valid),
    .mix_stall (mix_stall),
    .mix       (mix)
);

`default_nettype wire
